### design/delayed_error_flag_register_top_defines.svh
// assertion macros for the delayed error flag register
`ifndef DELAYED_ERROR_FLAG_REGISTER_TOP_DEFINES_SVH
`define DELAYED_ERROR_FLAG_REGISTER_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define DEFR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence from the next cycle on
`define DEFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/defr_pkg.sv
// shared types and constants of the delayed error flag register
package defr_pkg;

    localparam int WORD_W = 64;
    localparam int FUNC_W = 2;
    localparam int REQ_W  = 16;
    localparam int CNT_W  = 17;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNSET  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REINIT = 2'd3;

    // register indexes
    localparam logic REG_EXCL = 1'b0;
    localparam logic REG_INIT = 1'b1;

    // counter constants
    localparam logic signed [CNT_W-1:0] CNT_NEG_ONE = '1;
    localparam logic signed [CNT_W-1:0] CNT_ZERO    = '0;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic exec;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_set;
    } t_dp_sts;

endpackage

### design/defr_ctrl.sv
// sequencing state machine of the delayed error flag register
module defr_ctrl import defr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_set_done
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CALC = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: n_state = S_CALC;
            S_CALC: n_state = S_DONE;
            S_DONE: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // handshake and datapath commands
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.read  = (r_state == S_READ);
    assign o_cmd.exec  = (r_state == S_CALC);
    assign o_set_done  = (r_state == S_DONE) && i_sts.is_set;

endmodule

### design/defr_dp.sv
// flag word, counter memory and update logic of the delayed error flag register
module defr_dp import defr_pkg::*; #(
    parameter int FLAG_BITS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [WORD_W-1:0]       i_flag_mask,
    input  logic [REQ_W-1:0]        i_required_count,
    input  logic                    i_excl,
    input  logic [WORD_W-1:0]       i_init_flags,
    output logic [WORD_W-1:0]       o_flags_out,
    output logic                    o_raised,
    output logic signed [CNT_W-1:0] o_count_out
);

    localparam int IDX_W = $clog2(FLAG_BITS);

    // captured request
    logic [FUNC_W-1:0]    r_func;
    logic [FLAG_BITS-1:0] r_mask;
    logic [REQ_W-1:0]     r_req;

    // flag word and counter bookkeeping
    logic [FLAG_BITS-1:0] r_flags;
    logic [FLAG_BITS-1:0] n_flags;
    logic [FLAG_BITS-1:0] r_vld;
    logic [FLAG_BITS-1:0] n_vld;
    logic                 r_dflt_neg;
    logic                 n_dflt_neg;

    // counter memory and its read port
    logic signed [CNT_W-1:0] r_cnt_mem [FLAG_BITS];
    logic signed [CNT_W-1:0] r_rd_data;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        top_idx;

    // result
    logic                    r_raised;
    logic                    n_raised;
    logic signed [CNT_W-1:0] r_count;
    logic signed [CNT_W-1:0] n_count;
    logic                    mem_we;

    logic signed [CNT_W-1:0] kept;
    logic signed [CNT_W:0]   kept_x;
    logic signed [CNT_W:0]   limit;
    logic                    hit;
    logic [FLAG_BITS-1:0]    base;

    // capture the request on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_mask <= i_flag_mask[FLAG_BITS-1:0];
            r_req  <= i_required_count;
        end
    end

    // highest set bit of the mask, zero when the mask is empty
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < FLAG_BITS; i++) begin
            if (r_mask[i]) top_idx = IDX_W'(i);
        end
    end

    // registered counter read
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= r_cnt_mem[top_idx];
            r_idx     <= top_idx;
        end
    end

    // counter memory write, only in the update step
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_cnt_mem[r_idx] <= n_count;
        end
    end

    // stale entries read as the last bulk value
    assign kept   = r_vld[r_idx] ? r_rd_data : (r_dflt_neg ? CNT_NEG_ONE : CNT_ZERO);
    assign kept_x = {kept[CNT_W-1], kept};
    assign limit  = $signed({2'b00, r_req}) - $signed((CNT_W+1)'(1));
    assign hit    = (r_req == '0) || (kept_x >= limit);
    assign base   = i_excl ? '0 : r_flags;

    // update of word, counters and result
    always_comb begin
        n_flags    = r_flags;
        n_vld      = r_vld;
        n_dflt_neg = r_dflt_neg;
        n_raised   = 1'b0;
        n_count    = kept;
        mem_we     = 1'b0;
        unique case (r_func)
            FUNC_SET: begin
                if (i_excl) begin
                    n_vld      = '0;
                    n_dflt_neg = 1'b0;
                end
                n_vld[r_idx] = 1'b1;
                mem_we       = 1'b1;
                if (hit) begin
                    n_flags  = base | r_mask;
                    n_count  = CNT_ZERO;
                    n_raised = 1'b1;
                end else begin
                    n_flags = base;
                    n_count = kept + $signed(CNT_W'(1));
                end
            end
            FUNC_UNSET: begin
                n_flags      = r_flags & ~r_mask;
                n_vld[r_idx] = 1'b1;
                n_count      = CNT_ZERO;
                mem_we       = 1'b1;
            end
            FUNC_CLEAR: begin
                n_flags    = '0;
                n_vld      = '0;
                n_dflt_neg = 1'b0;
                n_count    = CNT_ZERO;
            end
            FUNC_REINIT: begin
                n_flags    = i_init_flags[FLAG_BITS-1:0];
                n_vld      = '0;
                n_dflt_neg = 1'b1;
                n_count    = CNT_NEG_ONE;
            end
            default: begin
                n_flags = r_flags;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags    <= '0;
            r_vld      <= '0;
            r_dflt_neg <= 1'b1;
        end else if (i_cmd.exec) begin
            r_flags    <= n_flags;
            r_vld      <= n_vld;
            r_dflt_neg <= n_dflt_neg;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_raised <= n_raised;
            r_count  <= n_count;
        end
    end

    assign o_flags_out  = WORD_W'(r_flags);
    assign o_raised     = r_raised;
    assign o_count_out  = r_count;
    assign o_sts.is_set = (r_func == FUNC_SET);

endmodule

### design/delayed_error_flag_register_top.sv
// after an input transfer the controller passes the read and update states before the result is valid
// one item in flight at a time: no new input is taken until the result has been taken
// the counter memory read is registered, which sets the read and update steps
// reset (synchronous, active low): flag word 0, all counters read as -1,
// exclusive_mode and initial_flags 0, controller idle
module delayed_error_flag_register_top import defr_pkg::*; #(
    parameter int FLAG_BITS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [WORD_W-1:0]       i_flag_mask,
    input  logic [REQ_W-1:0]        i_required_count,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [WORD_W-1:0]       o_flags_out,
    output logic                    o_raised,
    output logic signed [CNT_W-1:0] o_count_out,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [WORD_W-1:0]       pwdata,
    output logic [WORD_W-1:0]       prdata,
    output logic                    pready
);

    `include "delayed_error_flag_register_top_defines.svh"

    logic              r_excl;
    logic [WORD_W-1:0] r_init;
    logic              cfg_wr;
    logic              set_done;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_excl <= 1'b0;
            r_init <= '0;
        end else if (cfg_wr) begin
            if (paddr[3] == REG_EXCL) r_excl <= pwdata[0];
            if (paddr[3] == REG_INIT) r_init <= pwdata;
        end
    end

    // register readback
    assign prdata = (paddr[3] == REG_INIT) ? r_init : {{(WORD_W-1){1'b0}}, r_excl};

    defr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_set_done  (set_done)
    );

    defr_dp #(
        .FLAG_BITS (FLAG_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_func           (i_func),
        .i_flag_mask      (i_flag_mask),
        .i_required_count (i_required_count),
        .i_excl           (r_excl),
        .i_init_flags     (r_init),
        .o_flags_out      (o_flags_out),
        .o_raised         (o_raised),
        .o_count_out      (o_count_out)
    );

    // checks
    `DEFR_ASSERT_SAME(a_no_accept_while_busy, o_out_valid, !o_in_ready, "input taken while result pending")
    `DEFR_ASSERT_NEXT(a_result_latency, (i_in_valid && o_in_ready), (##2 o_out_valid), "result not valid three cycles after transfer")
    `DEFR_ASSERT_SAME(a_raised_zero_count, (o_out_valid && o_raised), (o_count_out == CNT_ZERO), "raised flags with nonzero counter")
    `DEFR_ASSERT_SAME(a_raised_only_on_set, (o_out_valid && o_raised), set_done, "raised on a request other than set")

endmodule
